### hw/rtl/tlf_pkg.sv
// Shared types, character codes and configuration constants for the text line
// number and escape formatter. No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package tlf_pkg;

    // Number of decimal digits in a printed line number.
    localparam int NUMBER_DIGITS = 6;
    localparam int NUM_W         = 4 * NUMBER_DIGITS;
    localparam int DIG_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_UPPER_I   = 8'h49;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    // Numbering modes. The unused code behaves as no numbering.
    localparam logic [1:0] NUM_OFF      = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_MODE      = 3'd0,
        CFG_SQUEEZE_BLANK    = 3'd1,
        CFG_SHOW_ENDS        = 3'd2,
        CFG_SHOW_TABS        = 3'd3,
        CFG_SHOW_NONPRINTING = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    // One classified input byte, as handed from the front to the back.
    typedef struct packed {
        logic             has_num;
        logic [NUM_W-1:0] number_bcd;
        logic             pre_valid;
        logic [7:0]       pre_byte;
        logic [7:0]       main_byte;
    } t_cmd;

    // Queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hw/rtl/tlf_front.sv
// Front part of the formatter: accepts input beats, tracks line state and the
// BCD line counter, and turns each byte into a command. Depends on tlf_pkg.
`timescale 1ns / 1ps

module tlf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlf_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_text_byte,
    input  logic           i_new_file,
    input  tlf_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output tlf_pkg::t_cmd  o_cmd
);
    import tlf_pkg::*;

    function automatic logic [NUM_W-1:0] bcd_inc(input logic [NUM_W-1:0] v);
        logic             all9;
        logic             carry;
        logic [3:0]       d;
        logic [NUM_W-1:0] res;
        all9 = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9) begin
                all9 = 1'b0;
            end
        end
        carry = !all9;
        res   = v;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = v[4*i +: 4];
            if (carry) begin
                if (d >= 4'd9) begin
                    res[4*i +: 4] = 4'd0;
                end else begin
                    res[4*i +: 4] = d + 4'd1;
                    carry         = 1'b0;
                end
            end
        end
        return res;
    endfunction

    logic [NUM_W-1:0] r_num, n_num;
    logic             r_start, n_start;
    logic             r_prev, n_prev;

    logic             accept;
    logic [NUM_W-1:0] eff_num;
    logic             eff_start, eff_prev;
    logic             is_nl, is_tab, display, drop, has_num;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        eff_num   = i_new_file ? NUM_W'(1) : r_num;
        eff_start = i_new_file || r_start;
        eff_prev  = i_new_file ? 1'b0 : r_prev;
        is_nl     = (i_text_byte == CH_NL);
        is_tab    = (i_text_byte == CH_TAB);
        display   = i_cfg.show_nonprinting || i_cfg.show_ends || i_cfg.show_tabs;
        drop      = eff_start && is_nl && i_cfg.squeeze_blank && eff_prev;
        if (is_nl) begin
            has_num = eff_start && !drop && (i_cfg.number_mode == NUM_ALL);
        end else begin
            has_num = eff_start && ((i_cfg.number_mode == NUM_ALL) ||
                                    (i_cfg.number_mode == NUM_NONBLANK));
        end

        // Character escape classification.
        o_cmd.has_num    = has_num;
        o_cmd.number_bcd = eff_num;
        o_cmd.pre_valid  = 1'b0;
        o_cmd.pre_byte   = CH_CARET;
        o_cmd.main_byte  = i_text_byte;
        if (is_nl) begin
            o_cmd.pre_valid = i_cfg.show_ends;
            o_cmd.pre_byte  = CH_DOLLAR;
        end else if (is_tab) begin
            if (i_cfg.show_tabs) begin
                o_cmd.pre_valid = 1'b1;
                o_cmd.main_byte = CH_UPPER_I;
            end
        end else if (display && (i_text_byte < CTRL_LIMIT)) begin
            o_cmd.pre_valid = 1'b1;
            o_cmd.main_byte = i_text_byte + CARET_OFFSET;
        end else if (display && (i_text_byte == CH_DEL)) begin
            o_cmd.pre_valid = 1'b1;
            o_cmd.main_byte = CH_QMARK;
        end

        // Line state update.
        n_num   = r_num;
        n_start = r_start;
        n_prev  = r_prev;
        if (accept) begin
            n_num   = has_num ? bcd_inc(eff_num) : eff_num;
            n_start = eff_start;
            n_prev  = eff_prev;
            if (eff_start) begin
                if (is_nl) begin
                    if (!drop) begin
                        n_prev = 1'b1;
                    end
                end else begin
                    n_prev  = 1'b0;
                    n_start = 1'b0;
                end
            end else if (is_nl) begin
                n_start = 1'b1;
                n_prev  = 1'b0;
            end
        end
    end

    assign o_push = accept && !drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num   <= NUM_W'(1);
            r_start <= 1'b1;
            r_prev  <= 1'b0;
        end else begin
            r_num   <= n_num;
            r_start <= n_start;
            r_prev  <= n_prev;
        end
    end

endmodule

### hw/rtl/tlf_queue.sv
// Short command queue between the front and back parts of the formatter.
// Depends on tlf_pkg for the command type and depth.
`timescale 1ns / 1ps

module tlf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tlf_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output tlf_pkg::t_cmd     o_head,
    output tlf_pkg::t_q_stat  o_stat
);
    import tlf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/tlf_back.sv
// Back part of the formatter: expands the command at the queue head into
// output bytes and holds them in the output register. Depends on tlf_pkg.
`timescale 1ns / 1ps

module tlf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlf_pkg::t_cmd     i_head,
    input  tlf_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_data,
    output logic              o_last
);
    import tlf_pkg::*;

    typedef enum logic [3:0] {
        BS_DIGIT = 4'b0001,
        BS_TAB   = 4'b0010,
        BS_PRE   = 4'b0100,
        BS_MAIN  = 4'b1000
    } t_bstate;

    localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NUMBER_DIGITS - 1);

    t_bstate          r_state, n_state, cur_state;
    logic             r_active, n_active;
    logic [DIG_W-1:0] r_dig, n_dig, cur_dig;
    logic             r_seen, n_seen, cur_seen;
    logic             r_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic             load;
    logic [3:0]       digit;
    logic             show_digit;

    assign load = (!r_out_valid || i_ready) && !i_q_stat.empty;

    always_comb begin
        if (r_active) begin
            cur_state = r_state;
        end else if (i_head.has_num) begin
            cur_state = BS_DIGIT;
        end else if (i_head.pre_valid) begin
            cur_state = BS_PRE;
        end else begin
            cur_state = BS_MAIN;
        end
        cur_dig  = r_active ? r_dig : LAST_DIG;
        cur_seen = r_active && r_seen;

        digit      = i_head.number_bcd[{cur_dig, 2'b00} +: 4];
        show_digit = cur_seen || (digit != 4'd0) || (cur_dig == '0);

        n_state    = cur_state;
        n_active   = r_active;
        n_dig      = cur_dig;
        n_seen     = cur_seen;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        o_pop      = 1'b0;

        if (load) begin
            n_active   = 1'b1;
            n_out_last = 1'b0;
            case (cur_state)
                BS_DIGIT: begin
                    n_out_data = show_digit ? (CH_ZERO + {4'd0, digit}) : CH_SPACE;
                    n_seen     = show_digit;
                    if (cur_dig == '0) begin
                        n_state = BS_TAB;
                    end else begin
                        n_dig = cur_dig - DIG_W'(1);
                    end
                end
                BS_TAB: begin
                    n_out_data = CH_TAB;
                    n_state    = i_head.pre_valid ? BS_PRE : BS_MAIN;
                end
                BS_PRE: begin
                    n_out_data = i_head.pre_byte;
                    n_state    = BS_MAIN;
                end
                BS_MAIN: begin
                    n_out_data = i_head.main_byte;
                    n_out_last = 1'b1;
                    n_active   = 1'b0;
                    o_pop      = 1'b1;
                end
                default: begin
                    n_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_MAIN;
            r_active    <= 1'b0;
            r_dig       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_dig    <= n_dig;
            r_seen   <= n_seen;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

### hw/rtl/text_line_number_and_escape_formatter_top.sv
// Top level of the text line number and escape formatter: configuration
// registers plus the front, queue and back parts. Depends on tlf_pkg and all tlf_ modules.
`timescale 1ns / 1ps

// The block takes one text byte per input beat on the s_axis channel, with
// tuser set on the first byte of a new file, and gives formatted bytes on the
// m_axis channel, tlast marking the final output beat caused by an input byte.
// A line start may emit six right-justified digits and a tab before the byte;
// escapes emit a caret pair, show-ends emits a dollar sign before a newline.
// A squeezed empty line gives no output beat at all.
// The front part classifies a byte in the cycle it is accepted and writes one
// command into a four-entry queue; the back part expands it into 1 to 9 beats,
// one per cycle while the receiver is ready, into the output register. An input
// beat goes into the queue and from there into the output register. Throughput is
// one input beat per cycle for bytes that give one output beat, while the receiver
// is ready; the back part pops a command with its last beat. Input is accepted
// while the queue has room, so a stalled receiver only blocks the input once four
// commands are waiting. Reset (synchronous, active low) clears all configuration
// to zero, sets the line number to one and marks the start of a line; the queue
// is emptied. Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_wdata;
// the user must write it only while idle, which the block does not enforce.

module text_line_number_and_escape_formatter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tlf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] text_byte
    input  logic                             i_s_axis_tuser,  // [0] new_file
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata,  // [7:0] out_byte
    output logic                             o_m_axis_tlast
);
    import tlf_pkg::*;

    t_cfg    r_cfg;
    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd;
    t_cmd    w_head;
    t_q_stat w_q_stat;

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_wdata[1:0];
                CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_wdata[0];
                CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_wdata[0];
                CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_wdata[0];
                CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_wdata[0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    // Front: line state, counter and classification of each accepted byte.
    tlf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_text_byte (i_s_axis_tdata),
        .i_new_file  (i_s_axis_tuser),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    // Queue decoupling the two parts.
    tlf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back: expansion of each command into output beats.
    tlf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // The front never writes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("command written into a full queue");

    // The back never takes a command from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("command taken from an empty queue");

    // After reset no output beat is offered.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
